>>> rtl/core/ffca_pkg.sv
// Shared types and constants for the first-fit coalescing allocator.
package ffca_pkg;

    localparam int ADDR_BITS     = 20;
    localparam int ID_BITS       = 10;
    localparam int STATUS_BITS   = 3;
    localparam int OP_BITS       = 2;
    localparam int MAX_NODES_DEF = 1024;

    localparam logic [ADDR_BITS-1:0] HEAP_SIZE_RST = 20'hFFFFF;

    localparam logic [OP_BITS-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_BITS-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_QUERY = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_ALLOC_OK   = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_ALLOC_FAIL = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FREE_OK    = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_FREE_FAIL  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FOUND      = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_NO_REGION  = 3'd5;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [ADDR_BITS-1:0]   address;
        logic [ADDR_BITS-1:0]   region_end;
        logic [ID_BITS-1:0]     given_id;
    } result_t;

endpackage

>>> rtl/core/ffca_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/ffca_core.sv
// Sequencer and datapath: walks the free list one node per cycle.
module ffca_core
    import ffca_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [ADDR_BITS-1:0]   cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [OP_BITS-1:0]     in_op,
    input  logic [ADDR_BITS-1:0]   in_size,
    input  logic [ID_BITS-1:0]     in_id,
    input  logic [ID_BITS-1:0]     in_k,
    output logic                   res_valid,
    input  logic                   res_ready,
    output result_t                res
);

    localparam int IDX = $clog2(MAX_NODES);
    localparam logic [IDX-1:0] NODE_LAST = IDX'(MAX_NODES - 1);
    localparam logic [IDX-1:0] NODE_ONE  = IDX'(1);
    localparam logic [IDX-1:0] NODE_NIL  = '0;

    typedef enum logic [14:0] {
        S_INIT  = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_AWALK = 15'b000000000000100,
        S_AW1   = 15'b000000000001000,
        S_AW2   = 15'b000000000010000,
        S_AW3   = 15'b000000000100000,
        S_AFAIL = 15'b000000001000000,
        S_FMAP  = 15'b000000010000000,
        S_FBLK  = 15'b000000100000000,
        S_FBB   = 15'b000001000000000,
        S_FWALK = 15'b000010000000000,
        S_FFIX1 = 15'b000100000000000,
        S_FFIX2 = 15'b001000000000000,
        S_QWALK = 15'b010000000000000,
        S_RESP  = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_BITS-1:0] heap_reg, heap_next;
    logic [IDX-1:0] head_reg, head_next;
    logic [IDX-1:0] used_reg, used_next;
    logic [IDX-1:0] ids_reg, ids_next;
    logic [IDX-1:0] map_reg, map_next;
    logic [ADDR_BITS-1:0] size_reg, size_next;
    logic [ID_BITS-1:0] cnt_reg, cnt_next;
    logic [IDX-1:0] cur_reg, cur_next;
    logic [IDX-1:0] prev_reg, prev_next;
    logic [IDX-1:0] blk_reg, blk_next;
    logic [ADDR_BITS-1:0] bl_reg, bl_next;
    logic [ADDR_BITS-1:0] br_reg, br_next;
    logic [IDX-1:0] pos_reg, pos_next;
    logic [ADDR_BITS-1:0] pos_end_reg, pos_end_next;
    logic [IDX-1:0] nx_reg, nx_next;
    logic [ADDR_BITS-1:0] nx_start_reg, nx_start_next;
    logic [ADDR_BITS-1:0] nx_end_reg, nx_end_next;
    logic [IDX-1:0] nx_link_reg, nx_link_next;
    logic [ADDR_BITS-1:0] snew_reg, snew_next;
    logic [IDX-1:0] hnext_reg, hnext_next;
    logic empty_reg, empty_next;
    result_t res_reg, res_next;

    logic [IDX-1:0] node_raddr;
    logic [ADDR_BITS-1:0] rd_s, rd_e;
    logic [IDX-1:0] rd_n, map_rd;
    logic s_we, e_we, n_we, m_we;
    logic [IDX-1:0] s_wa, e_wa, n_wa;
    logic [ADDR_BITS-1:0] s_wd, e_wd;
    logic [IDX-1:0] n_wd, m_wd;

    logic [ADDR_BITS-1:0] diff, sum;
    logic fits, c1, c2, c3;

    ffca_ram #(.WIDTH(ADDR_BITS), .DEPTH(MAX_NODES)) u_start (
        .aclk(aclk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(node_raddr), .rdata(rd_s));
    ffca_ram #(.WIDTH(ADDR_BITS), .DEPTH(MAX_NODES)) u_end (
        .aclk(aclk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(node_raddr), .rdata(rd_e));
    ffca_ram #(.WIDTH(IDX), .DEPTH(MAX_NODES)) u_next (
        .aclk(aclk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(node_raddr), .rdata(rd_n));
    ffca_ram #(.WIDTH(IDX), .DEPTH(MAX_NODES)) u_map (
        .aclk(aclk), .we(m_we), .waddr(map_reg), .wdata(m_wd), .raddr(map_reg),
        .rdata(map_rd));

    assign diff = rd_e - rd_s;
    assign sum  = rd_s + size_reg;
    assign fits = (rd_e >= rd_s) && (diff >= size_reg);
    assign c1 = (pos_reg != NODE_NIL) && (nx_reg != NODE_NIL) && (bl_reg == pos_end_reg)
                && (br_reg == nx_start_reg);
    assign c2 = (pos_reg != NODE_NIL) && (bl_reg == pos_end_reg);
    assign c3 = (nx_reg != NODE_NIL) && (br_reg == nx_start_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;

    always_comb begin
        state_next    = state_reg;
        heap_next     = heap_reg;
        head_next     = head_reg;
        used_next     = used_reg;
        ids_next      = ids_reg;
        map_next      = map_reg;
        size_next     = size_reg;
        cnt_next      = cnt_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        blk_next      = blk_reg;
        bl_next       = bl_reg;
        br_next       = br_reg;
        pos_next      = pos_reg;
        pos_end_next  = pos_end_reg;
        nx_next       = nx_reg;
        nx_start_next = nx_start_reg;
        nx_end_next   = nx_end_reg;
        nx_link_next  = nx_link_reg;
        snew_next     = snew_reg;
        hnext_next    = hnext_reg;
        empty_next    = empty_reg;
        res_next      = res_reg;
        node_raddr    = head_reg;
        s_we = 1'b0; s_wa = cur_reg; s_wd = snew_reg;
        e_we = 1'b0; e_wa = pos_reg; e_wd = br_reg;
        n_we = 1'b0; n_wa = cur_reg; n_wd = NODE_NIL;
        m_we = 1'b0; m_wd = NODE_NIL;

        case (state_reg)
            S_INIT: begin
                s_we = 1'b1; s_wa = NODE_ONE; s_wd = '0;
                e_we = 1'b1; e_wa = NODE_ONE; e_wd = heap_reg;
                n_we = 1'b1; n_wa = NODE_ONE;
                head_next  = NODE_ONE;
                used_next  = NODE_ONE;
                ids_next   = NODE_NIL;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (in_valid) begin
                    res_next  = '0;
                    size_next = in_size;
                    cnt_next  = in_k;
                    cur_next  = head_reg;
                    prev_next = NODE_NIL;
                    case (in_op)
                        OP_ALLOC: begin
                            res_next.status = ST_ALLOC_FAIL;
                            if (ids_reg == NODE_LAST) begin
                                state_next = S_RESP;
                            end else begin
                                ids_next          = ids_reg + NODE_ONE;
                                map_next          = ids_reg + NODE_ONE;
                                res_next.given_id = ID_BITS'(ids_reg + NODE_ONE);
                                if (head_reg == NODE_NIL || used_reg == NODE_LAST) begin
                                    state_next = S_AFAIL;
                                end else begin
                                    state_next = S_AWALK;
                                end
                            end
                        end
                        OP_FREE: begin
                            map_next = IDX'(in_id);
                            if (in_id == '0 || 32'(in_id) > 32'(ids_reg)) begin
                                res_next.status = ST_FREE_FAIL;
                                state_next      = S_RESP;
                            end else begin
                                state_next = S_FMAP;
                            end
                        end
                        OP_QUERY: begin
                            if (head_reg == NODE_NIL) begin
                                res_next.status = ST_NO_REGION;
                                state_next      = S_RESP;
                            end else begin
                                state_next = S_QWALK;
                            end
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_AWALK: begin
                node_raddr = rd_n;
                if (fits) begin
                    res_next.address = rd_s;
                    snew_next        = sum;
                    empty_next       = (sum == rd_e);
                    hnext_next       = rd_n;
                    state_next       = S_AW1;
                end else if (rd_n == NODE_NIL) begin
                    state_next = S_AFAIL;
                end else begin
                    prev_next = cur_reg;
                    cur_next  = rd_n;
                end
            end
            S_AW1: begin
                s_we = 1'b1; s_wa = used_reg + NODE_ONE; s_wd = res_reg.address;
                e_we = 1'b1; e_wa = used_reg + NODE_ONE; e_wd = snew_reg;
                n_we = 1'b1; n_wa = used_reg + NODE_ONE;
                m_we = 1'b1; m_wd = used_reg + NODE_ONE;
                used_next  = used_reg + NODE_ONE;
                state_next = S_AW2;
            end
            S_AW2: begin
                s_we = 1'b1;
                n_we = empty_reg;
                res_next.status = ST_ALLOC_OK;
                state_next = empty_reg ? S_AW3 : S_RESP;
            end
            S_AW3: begin
                if (prev_reg == NODE_NIL) begin
                    head_next = hnext_reg;
                end else begin
                    n_we = 1'b1; n_wa = prev_reg; n_wd = hnext_reg;
                end
                state_next = S_RESP;
            end
            S_AFAIL: begin
                m_we = 1'b1;
                state_next = S_RESP;
            end
            S_FMAP: begin
                state_next = S_FBLK;
            end
            S_FBLK: begin
                node_raddr = map_rd;
                blk_next   = map_rd;
                if (map_rd == NODE_NIL) begin
                    res_next.status = ST_FREE_FAIL;
                    state_next      = S_RESP;
                end else begin
                    state_next = S_FBB;
                end
            end
            S_FBB: begin
                bl_next      = rd_s;
                br_next      = rd_e;
                pos_next     = NODE_NIL;
                pos_end_next = '0;
                nx_next      = NODE_NIL;
                cur_next     = head_reg;
                state_next   = (head_reg == NODE_NIL) ? S_FFIX1 : S_FWALK;
            end
            S_FWALK: begin
                node_raddr = rd_n;
                if (bl_reg >= rd_e) begin
                    pos_next     = cur_reg;
                    pos_end_next = rd_e;
                    nx_next      = rd_n;
                    cur_next     = rd_n;
                    if (rd_n == NODE_NIL) begin
                        state_next = S_FFIX1;
                    end
                end else begin
                    nx_next       = cur_reg;
                    nx_start_next = rd_s;
                    nx_end_next   = rd_e;
                    nx_link_next  = rd_n;
                    state_next    = S_FFIX1;
                end
            end
            S_FFIX1: begin
                m_we = 1'b1;
                if (c1) begin
                    e_we = 1'b1; e_wd = nx_end_reg;
                    n_we = 1'b1; n_wa = pos_reg; n_wd = nx_link_reg;
                end else if (c2) begin
                    e_we = 1'b1;
                end else if (c3) begin
                    s_we = 1'b1; s_wa = nx_reg; s_wd = bl_reg;
                end else begin
                    n_we = 1'b1; n_wa = blk_reg; n_wd = nx_reg;
                end
                state_next = S_FFIX2;
            end
            S_FFIX2: begin
                if (c1) begin
                    n_we = 1'b1; n_wa = nx_reg;
                end else if (!c2 && !c3) begin
                    if (pos_reg == NODE_NIL) begin
                        head_next = blk_reg;
                    end else begin
                        n_we = 1'b1; n_wa = pos_reg; n_wd = blk_reg;
                    end
                end
                res_next.status = ST_FREE_OK;
                state_next      = S_RESP;
            end
            S_QWALK: begin
                node_raddr = rd_n;
                if (cnt_reg == '0) begin
                    res_next.status     = ST_FOUND;
                    res_next.address    = rd_s;
                    res_next.region_end = rd_e;
                    state_next          = S_RESP;
                end else begin
                    cnt_next = cnt_reg - ID_BITS'(1);
                    cur_next = rd_n;
                    if (rd_n == NODE_NIL) begin
                        res_next.status = ST_NO_REGION;
                        state_next      = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase

        if (cfg_wr_en) begin
            heap_next  = cfg_wr_data;
            state_next = S_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            heap_reg  <= HEAP_SIZE_RST;
            head_reg  <= NODE_ONE;
            used_reg  <= NODE_ONE;
            ids_reg   <= NODE_NIL;
        end else begin
            state_reg <= state_next;
            heap_reg  <= heap_next;
            head_reg  <= head_next;
            used_reg  <= used_next;
            ids_reg   <= ids_next;
        end
    end

    always_ff @(posedge aclk) begin
        map_reg      <= map_next;
        size_reg     <= size_next;
        cnt_reg      <= cnt_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        blk_reg      <= blk_next;
        bl_reg       <= bl_next;
        br_reg       <= br_next;
        pos_reg      <= pos_next;
        pos_end_reg  <= pos_end_next;
        nx_reg       <= nx_next;
        nx_start_reg <= nx_start_next;
        nx_end_reg   <= nx_end_next;
        nx_link_reg  <= nx_link_next;
        snew_reg     <= snew_next;
        hnext_reg    <= hnext_next;
        empty_reg    <= empty_next;
        res_reg      <= res_next;
    end

endmodule

>>> rtl/core/first_fit_coalescing_allocator_unit.sv
// Allocate, free and query walk the free list one node per cycle through the node RAM,
// visiting at most MAX_NODES-1 nodes; the result then reaches m_tvalid via the output register.
// Throughput: one word at a time; the next input word is taken once the result is
// handed to the output register, which may still be waiting on m_tready.
// Reset (aresetn low, synchronous) and each heap_size write start an initialization
// state that sets up the single free region; s_tready is low during it.
module first_fit_coalescing_allocator_unit
    import ffca_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [ADDR_BITS-1:0]   cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [39:0]            s_tdata,   // size[19:0], alloc_id[29:20], region_index[39:30]
    input  logic [OP_BITS-1:0]     s_tuser,   // op
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [55:0]            m_tdata,   // address[19:0], region_end[39:20], given_id[49:40]
    output logic [STATUS_BITS-1:0] m_tuser    // status
);

    logic    res_valid, res_ready;
    result_t res;
    logic    m_valid_reg;
    result_t m_res_reg;

    ffca_core #(.MAX_NODES(MAX_NODES)) u_core (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_op(s_tuser), .in_size(s_tdata[19:0]),
        .in_id(s_tdata[29:20]), .in_k(s_tdata[39:30]),
        .res_valid(res_valid), .res_ready(res_ready), .res(res)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {6'b0, m_res_reg.given_id, m_res_reg.region_end, m_res_reg.address};

endmodule

>>> rtl/core/ffca_chk.sv
// Port-level checker for the allocator, bound to the top level.
module ffca_chk
    import ffca_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   cfg_wr_en,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [55:0]            m_tdata,
    input logic [STATUS_BITS-1:0] m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again without processing");

    a_busy_after_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("ready during initialization");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_NO_REGION)
        else $error("status out of range");

    a_id_only_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_ALLOC_OK && m_tuser != ST_ALLOC_FAIL |-> m_tdata[49:40] == '0)
        else $error("given_id set on non-allocate result");

endmodule

bind first_fit_coalescing_allocator_unit ffca_chk u_ffca_chk (
    .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
